// ----- sv/arm_forward_kinematics_core_assert.svh -----
// Assertion helpers shared by the pipeline stages.
// Each helper expects signals named clk and rst_n in the module that uses it.
`ifndef ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/afk_pkg.sv -----
`default_nettype none

package afk_pkg;

  // Fraction bits of the sine and cosine values.
  localparam int TRIG_FRAC_BITS = 15;

  // Field widths.
  localparam int ANG_W  = 8;
  localparam int DEG_W  = 9;
  localparam int SLOT_W = 3;
  localparam int LEN_W  = 13;
  localparam int POS_W  = 16;

  // Datapath widths.
  localparam int TAB_W     = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W    = TAB_W + 1;
  localparam int TAB_IDX_W = 7;
  localparam int PROD_W    = LEN_W + 1 + TRIG_W;
  localparam int SUM_W     = PROD_W;
  localparam int XY_W      = TRIG_W + SUM_W;

  // Full turn in degrees.
  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_UPPER_ARM,
    REG_FOREARM,
    REG_HAND,
    REG_BASE_HEIGHT
  } reg_idx_t;

  localparam logic [LEN_W-1:0] UPPER_ARM_RST   = 13'd3712;
  localparam logic [LEN_W-1:0] FOREARM_RST     = 13'd4736;
  localparam logic [LEN_W-1:0] HAND_RST        = 13'd512;
  localparam logic [LEN_W-1:0] BASE_HEIGHT_RST = 13'd1920;

  // Pi in Q30, used only while the table is built.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [DEG_W-1:0]         deg_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [90:0][TAB_W-1:0]   sine_tab_t;

  typedef struct packed {
    logic [ANG_W-1:0] base;
    logic [ANG_W-1:0] shoulder;
    logic [ANG_W-1:0] elbow;
    logic [ANG_W-1:0] wrist;
    slot_t            slot;
  } pose_t;

  typedef struct packed {
    len_t upper;
    len_t fore;
    len_t hand;
    len_t height;
  } link_cfg_t;

  typedef struct packed {
    deg_t  base;
    deg_t  a1;
    deg_t  a2;
    deg_t  a3;
    slot_t slot;
  } joint_ang_t;

  typedef struct packed {
    trig_t cos_b;
    trig_t sin_b;
    trig_t cos1;
    trig_t cos2;
    trig_t cos3;
    trig_t sin1;
    trig_t sin2;
    trig_t sin3;
    slot_t slot;
  } trig_set_t;

  typedef struct packed {
    sum_t  reach;
    sum_t  height;
    trig_t cos_b;
    trig_t sin_b;
    slot_t slot;
  } arm_sum_t;

  // Quarter-wave sine table built at elaboration from a Q30 Taylor series,
  // rounded half up to TRIG_FRAC_BITS fraction bits.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int d = 0; d <= 90; d++) begin
      x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum    = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      tab[d] = TAB_W'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Sine of an angle below 360 degrees, by quadrant symmetry.
  function automatic trig_t sin_lookup(deg_t a);
    logic [TAB_W-1:0] mag;
    logic             neg;
    trig_t            mag_s;
    if (a <= 9'd90) begin
      mag = SINE_TAB[TAB_IDX_W'(a)];
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      mag = SINE_TAB[TAB_IDX_W'(9'd180 - a)];
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      mag = SINE_TAB[TAB_IDX_W'(a - 9'd180)];
      neg = 1'b1;
    end else begin
      mag = SINE_TAB[TAB_IDX_W'(DEG_FULL - a)];
      neg = 1'b1;
    end
    mag_s = $signed({1'b0, mag});
    return neg ? -mag_s : mag_s;
  endfunction

  // Cosine as the sine of the angle advanced by a quarter turn.
  function automatic trig_t cos_lookup(deg_t a);
    logic [DEG_W:0] s;
    s = {1'b0, a} + 10'd90;
    if (s >= {1'b0, DEG_FULL}) begin
      s = s - {1'b0, DEG_FULL};
    end
    return sin_lookup(DEG_W'(s));
  endfunction

endpackage

`default_nettype wire

// ----- sv/afk_angle.sv -----
`default_nettype none
`include "arm_forward_kinematics_core_assert.svh"

module afk_angle import afk_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pose_valid,
  output logic           pose_ready,
  input  wire pose_t     pose,
  output logic           trig_valid,
  input  wire logic      trig_ready,
  output trig_set_t      trig
);

  localparam trig_t TRIG_ONE = trig_t'(1 << TRIG_FRAC_BITS);

  joint_ang_t ang_r;
  joint_ang_t ang_nxt;
  logic       ang_valid_r;
  logic       ang_ready;
  trig_set_t  trig_r;
  trig_set_t  trig_nxt;
  logic       trig_valid_r;
  logic       trig_stage_ready;

  logic [DEG_W:0] sum2;
  logic [DEG_W:0] sum3;
  deg_t           a2;

  // Handshake: a stage takes a word when it is empty or its word moves on.
  assign trig_stage_ready = !trig_valid_r || trig_ready;
  assign ang_ready        = !ang_valid_r || trig_stage_ready;
  assign pose_ready       = ang_ready;

  // Joint angle sums reduced to one turn.
  always_comb begin
    sum2 = {2'b00, pose.shoulder} + {2'b00, pose.elbow};
    if (sum2 >= {1'b0, DEG_FULL}) begin
      a2 = DEG_W'(sum2 - {1'b0, DEG_FULL});
    end else begin
      a2 = DEG_W'(sum2);
    end
    sum3 = {1'b0, a2} + {2'b00, pose.wrist};
    ang_nxt.base = {1'b0, pose.base};
    ang_nxt.a1   = {1'b0, pose.shoulder};
    ang_nxt.a2   = a2;
    if (sum3 >= {1'b0, DEG_FULL}) begin
      ang_nxt.a3 = DEG_W'(sum3 - {1'b0, DEG_FULL});
    end else begin
      ang_nxt.a3 = DEG_W'(sum3);
    end
    ang_nxt.slot = pose.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_valid_r <= 1'b0;
    end else if (ang_ready) begin
      ang_valid_r <= pose_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ang_ready && pose_valid) begin
      ang_r <= ang_nxt;
    end
  end

  // Table lookups for every angle of the pose.
  always_comb begin
    trig_nxt.cos_b = cos_lookup(ang_r.base);
    trig_nxt.sin_b = sin_lookup(ang_r.base);
    trig_nxt.cos1  = cos_lookup(ang_r.a1);
    trig_nxt.cos2  = cos_lookup(ang_r.a2);
    trig_nxt.cos3  = cos_lookup(ang_r.a3);
    trig_nxt.sin1  = sin_lookup(ang_r.a1);
    trig_nxt.sin2  = sin_lookup(ang_r.a2);
    trig_nxt.sin3  = sin_lookup(ang_r.a3);
    trig_nxt.slot  = ang_r.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_valid_r <= 1'b0;
    end else if (trig_stage_ready) begin
      trig_valid_r <= ang_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (trig_stage_ready && ang_valid_r) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig_valid = trig_valid_r;
  assign trig       = trig_r;

  // Reduced angles stay inside one turn.
  `AFK_ASSERT_SAME(a_ang_range, ang_valid_r, (ang_r.a2 < DEG_FULL) && (ang_r.a3 < DEG_FULL), "angle sum not reduced below a full turn")
  // The looked-up base cosine and third-link sine never exceed unity.
  `AFK_ASSERT_SAME(a_trig_bound, trig_valid_r, (trig_r.cos_b <= TRIG_ONE) && (trig_r.cos_b >= -TRIG_ONE) && (trig_r.sin3 <= TRIG_ONE) && (trig_r.sin3 >= -TRIG_ONE), "trig value out of range")
  // A stalled word stays in the lookup stage.
  `AFK_ASSERT_NEXT(a_trig_hold, trig_valid_r && !trig_ready, trig_valid_r, "stalled lookup word lost")

endmodule

`default_nettype wire

// ----- sv/afk_link.sv -----
`default_nettype none

module afk_link import afk_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire link_cfg_t cfg,
  input  wire logic      trig_valid,
  output logic           trig_ready,
  input  wire trig_set_t trig,
  output logic           sum_valid,
  input  wire logic      sum_ready,
  output arm_sum_t       arm
);

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    prod_t rc1;
    prod_t rc2;
    prod_t rc3;
    prod_t zs1;
    prod_t zs2;
    prod_t zs3;
    trig_t cos_b;
    trig_t sin_b;
    slot_t slot;
  } link_prod_t;

  link_prod_t prod_r;
  link_prod_t prod_nxt;
  logic       prod_valid_r;
  logic       prod_ready;
  arm_sum_t   arm_r;
  arm_sum_t   arm_nxt;
  logic       arm_valid_r;
  logic       arm_ready;
  sum_t       h_term;

  assign arm_ready  = !arm_valid_r || sum_ready;
  assign prod_ready = !prod_valid_r || arm_ready;
  assign trig_ready = prod_ready;

  // Each link length times the cosine and sine of its absolute angle.
  always_comb begin
    prod_nxt.rc1   = $signed({1'b0, cfg.upper}) * trig.cos1;
    prod_nxt.rc2   = $signed({1'b0, cfg.fore})  * trig.cos2;
    prod_nxt.rc3   = $signed({1'b0, cfg.hand})  * trig.cos3;
    prod_nxt.zs1   = $signed({1'b0, cfg.upper}) * trig.sin1;
    prod_nxt.zs2   = $signed({1'b0, cfg.fore})  * trig.sin2;
    prod_nxt.zs3   = $signed({1'b0, cfg.hand})  * trig.sin3;
    prod_nxt.cos_b = trig.cos_b;
    prod_nxt.sin_b = trig.sin_b;
    prod_nxt.slot  = trig.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_r <= trig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && trig_valid) begin
      prod_r <= prod_nxt;
    end
  end

  // Planar reach and height, with the shoulder height scaled to the product.
  assign h_term = $signed(SUM_W'({cfg.height, {TRIG_FRAC_BITS{1'b0}}}));

  always_comb begin
    arm_nxt.reach  = prod_r.rc1 + prod_r.rc2 + prod_r.rc3;
    arm_nxt.height = h_term + prod_r.zs1 + prod_r.zs2 + prod_r.zs3;
    arm_nxt.cos_b  = prod_r.cos_b;
    arm_nxt.sin_b  = prod_r.sin_b;
    arm_nxt.slot   = prod_r.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_valid_r <= 1'b0;
    end else if (arm_ready) begin
      arm_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (arm_ready && prod_valid_r) begin
      arm_r <= arm_nxt;
    end
  end

  assign sum_valid = arm_valid_r;
  assign arm       = arm_r;

endmodule

`default_nettype wire

// ----- sv/afk_out.sv -----
`default_nettype none
`include "arm_forward_kinematics_core_assert.svh"

module afk_out import afk_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            sum_valid,
  output logic                 sum_ready,
  input  wire arm_sum_t        arm,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output slot_t                result_slot
);

  localparam int XR_W = XY_W - 2 * TRIG_FRAC_BITS;
  localparam int ZR_W = SUM_W - TRIG_FRAC_BITS;

  localparam logic signed [XY_W-1:0]  X_HALF = XY_W'(64'd1 << (2 * TRIG_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] Z_HALF = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));
  localparam logic signed [XR_W-1:0]  X_MAX  = XR_W'(32767);
  localparam logic signed [XR_W-1:0]  X_MIN  = XR_W'(-32768);
  localparam logic signed [ZR_W-1:0]  Z_MAX  = ZR_W'(32767);
  localparam logic signed [ZR_W-1:0]  Z_MIN  = ZR_W'(-32768);

  typedef logic signed [XY_W-1:0] xy_t;

  typedef struct packed {
    xy_t                     x;
    xy_t                     y;
    logic signed [POS_W-1:0] z;
    slot_t                   slot;
  } proj_t;

  proj_t                   prj_r;
  proj_t                   prj_nxt;
  logic                    prj_valid_r;
  logic                    prj_ready;
  logic                    res_valid_r;
  logic                    res_stage_ready;
  logic signed [POS_W-1:0] x_r;
  logic signed [POS_W-1:0] x_nxt;
  logic signed [POS_W-1:0] y_r;
  logic signed [POS_W-1:0] y_nxt;
  logic signed [POS_W-1:0] z_r;
  slot_t                   slot_r;

  logic signed [SUM_W-1:0] z_biased;
  logic signed [ZR_W-1:0]  z_round;
  logic signed [XY_W-1:0]  x_biased;
  logic signed [XY_W-1:0]  y_biased;
  logic signed [XR_W-1:0]  x_round;
  logic signed [XR_W-1:0]  y_round;

  assign res_stage_ready = !res_valid_r || res_ready;
  assign prj_ready       = !prj_valid_r || res_stage_ready;
  assign sum_ready       = prj_ready;

  // Project the reach onto x and y; round and saturate the height.
  always_comb begin
    z_biased  = arm.height + Z_HALF;
    z_round   = ZR_W'(z_biased >>> TRIG_FRAC_BITS);
    prj_nxt.x = arm.cos_b * arm.reach;
    prj_nxt.y = arm.sin_b * arm.reach;
    if (z_round > Z_MAX) begin
      prj_nxt.z = POS_W'(Z_MAX);
    end else if (z_round < Z_MIN) begin
      prj_nxt.z = POS_W'(Z_MIN);
    end else begin
      prj_nxt.z = POS_W'(z_round);
    end
    prj_nxt.slot = arm.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prj_valid_r <= 1'b0;
    end else if (prj_ready) begin
      prj_valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prj_ready && sum_valid) begin
      prj_r <= prj_nxt;
    end
  end

  // Round half up by both fraction scalings, then saturate x and y.
  always_comb begin
    x_biased = prj_r.x + X_HALF;
    y_biased = prj_r.y + X_HALF;
    x_round  = XR_W'(x_biased >>> (2 * TRIG_FRAC_BITS));
    y_round  = XR_W'(y_biased >>> (2 * TRIG_FRAC_BITS));
    if (x_round > X_MAX) begin
      x_nxt = POS_W'(X_MAX);
    end else if (x_round < X_MIN) begin
      x_nxt = POS_W'(X_MIN);
    end else begin
      x_nxt = POS_W'(x_round);
    end
    if (y_round > X_MAX) begin
      y_nxt = POS_W'(X_MAX);
    end else if (y_round < X_MIN) begin
      y_nxt = POS_W'(X_MIN);
    end else begin
      y_nxt = POS_W'(y_round);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_stage_ready) begin
      res_valid_r <= prj_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_stage_ready && prj_valid_r) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= prj_r.z;
      slot_r <= prj_r.slot;
    end
  end

  assign res_valid   = res_valid_r;
  assign pos_x       = x_r;
  assign pos_y       = y_r;
  assign pos_z       = z_r;
  assign result_slot = slot_r;

  // A word in the projection stage reaches the output register when it frees up.
  `AFK_ASSERT_NEXT(a_out_load, prj_valid_r && res_stage_ready, res_valid_r, "projected word not moved to output")

endmodule

`default_nettype wire

// ----- sv/arm_forward_kinematics_core.sv -----
// Forward kinematics of a four-joint arm. Each input word carries the base,
// shoulder, elbow and wrist angles in whole degrees and a slot tag; the result
// word gives the tool position x, y and z in two's complement with 8 fraction
// bits, saturated to 16 bits, plus the slot tag. The datapath is a six-stage
// pipeline (angle sums, table lookup, link products, sums, projection, round
// and saturate), so a pose enters every cycle unless a full pipeline is held
// by an output stall, and its result moves through the stages in that order.
// Each stage holds its word while the stage after it cannot take it, so empty
// stages still absorb new words during an output stall. Link lengths and
// shoulder height are set through the register port at byte addresses 0, 4, 8
// and 12 and must only be changed while no pose is in flight.
`default_nettype none

module arm_forward_kinematics_core import afk_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Pose input
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [ANG_W-1:0]        in_base_angle,
  input  wire logic [ANG_W-1:0]        in_shoulder_angle,
  input  wire logic [ANG_W-1:0]        in_elbow_angle,
  input  wire logic [ANG_W-1:0]        in_wrist_angle,
  input  wire logic [SLOT_W-1:0]       in_slot,
  // Position output
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [POS_W-1:0]      out_pos_x,
  output logic signed [POS_W-1:0]      out_pos_y,
  output logic signed [POS_W-1:0]      out_pos_z,
  output logic [SLOT_W-1:0]            out_result_slot,
  // Register port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  link_cfg_t cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_write;
  pose_t     pose;
  logic      trig_valid;
  logic      trig_ready;
  trig_set_t trig;
  logic      sum_valid;
  logic      sum_ready;
  arm_sum_t  arm;

  // Register port decode.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper  <= UPPER_ARM_RST;
      cfg_r.fore   <= FOREARM_RST;
      cfg_r.hand   <= HAND_RST;
      cfg_r.height <= BASE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_UPPER_ARM:   cfg_r.upper  <= pwdata[LEN_W-1:0];
        REG_FOREARM:     cfg_r.fore   <= pwdata[LEN_W-1:0];
        REG_HAND:        cfg_r.hand   <= pwdata[LEN_W-1:0];
        REG_BASE_HEIGHT: cfg_r.height <= pwdata[LEN_W-1:0];
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_UPPER_ARM:   prdata = DATA_W'(cfg_r.upper);
      REG_FOREARM:     prdata = DATA_W'(cfg_r.fore);
      REG_HAND:        prdata = DATA_W'(cfg_r.hand);
      REG_BASE_HEIGHT: prdata = DATA_W'(cfg_r.height);
    endcase
  end

  // Gather the pose word.
  assign pose.base     = in_base_angle;
  assign pose.shoulder = in_shoulder_angle;
  assign pose.elbow    = in_elbow_angle;
  assign pose.wrist    = in_wrist_angle;
  assign pose.slot     = in_slot;

  afk_angle u_angle (
    .clk        (clk),
    .rst_n      (rst_n),
    .pose_valid (in_valid),
    .pose_ready (in_ready),
    .pose       (pose),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig       (trig)
  );

  afk_link u_link (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig       (trig),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .arm        (arm)
  );

  afk_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .arm         (arm),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .pos_x       (out_pos_x),
    .pos_y       (out_pos_y),
    .pos_z       (out_pos_z),
    .result_slot (out_result_slot)
  );

endmodule

`default_nettype wire
